// ===== hw/rtl/nfcp_pkg.sv =====
// ----------------------------------------------------------------------------
// nfcp_pkg
// types, codes and character tables shared by the format code parser
// ----------------------------------------------------------------------------
package nfcp_pkg;

    localparam int MAX_SECTIONS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] ST_VALID    = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_SECTIONS = 3'd2;
    localparam logic [2:0] ST_QUOTES   = 3'd3;
    localparam logic [2:0] ST_PARENS   = 3'd4;

    localparam logic [2:0] CUR_NONE    = 3'd0;
    localparam logic [2:0] CUR_DOLLAR  = 3'd1;
    localparam logic [2:0] CUR_EURO    = 3'd2;
    localparam logic [2:0] CUR_POUND   = 3'd3;
    localparam logic [2:0] CUR_YEN     = 3'd4;
    localparam logic [2:0] CUR_GENERIC = 3'd5;

    localparam logic [4:0] FLAG_THOUSANDS = 5'h01;
    localparam logic [4:0] FLAG_PERCENT   = 5'h02;
    localparam logic [4:0] FLAG_PARENS    = 5'h04;
    localparam logic [4:0] FLAG_TEXT      = 5'h08;
    localparam logic [4:0] FLAG_EMPTY     = 5'h10;

    // element slots of one queued record, in emission order
    localparam int NSLOT = 6;
    localparam int SLOT_SUM_A = 3;
    localparam int SLOT_SUM_B = 4;
    localparam int SLOT_VERD  = 5;

    typedef struct packed {
        logic [2:0][7:0] b;
        logic [1:0]      n;
    } t_lits;

    typedef struct packed {
        logic       valid;
        logic [1:0] idx;
        logic [7:0] dec;
        logic [4:0] flags;
        logic [2:0] cur;
    } t_summary;

    typedef struct packed {
        t_lits      lits;
        logic       suffix;
        logic [1:0] lit_idx;
        t_summary   sum_a;
        t_summary   sum_b;
        logic       has_verdict;
        logic [2:0] status;
        logic       gen;
    } t_rec;

    function automatic t_lits add_lit(t_lits l, logic [7:0] v);
        t_lits r;
        r = l;
        if (l.n != 2'd3) begin
            r.b[l.n] = v;
            r.n = l.n + 2'd1;
        end
        return r;
    endfunction

    // letter pos of spelling sel: General, general, GENERAL
    function automatic logic [7:0] gen_char(logic [1:0] sel, logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0: c = 8'h67; 3'd1: c = 8'h65; 3'd2: c = 8'h6e; 3'd3: c = 8'h65;
            3'd4: c = 8'h72; 3'd5: c = 8'h61; default: c = 8'h6c;
        endcase
        if (sel == 2'd2 || (sel == 2'd0 && pos == 3'd0)) begin
            c = c & 8'hdf;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/number_format_code_parser_unit.sv =====
// ----------------------------------------------------------------------------
// number_format_code_parser_unit
// number-format code parser: byte stream in, literals, summaries, verdict out
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// input     in         push / full            code_byte, byte_present, code_end
// result    out        empty / pop            kind .. last_result
//
// one input byte per cycle while full is low; the front updates its state and
// queues at most one record in the same cycle, the back drains it at one result
// per cycle while the output is empty or popped; a byte yields up to five results,
// so bursts fill the record queue and full rises until the back catches up with pop
// reset is synchronous and clears parser and queue control state; held bytes and queue storage are not reset
module number_format_code_parser_unit #(
    parameter int MAX_SECTIONS = nfcp_pkg::MAX_SECTIONS_DEF,
    parameter int QUEUE_DEPTH  = nfcp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_code_byte,
    input  logic       i_byte_present,
    input  logic       i_code_end,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_to_suffix,
    output logic [1:0] o_section_index,
    output logic [7:0] o_decimals,
    output logic [4:0] o_section_flags,
    output logic [2:0] o_currency,
    output logic [2:0] o_status,
    output logic       o_is_general,
    output logic       o_last_result
);

    nfcp_pkg::t_rec rec_in, rec_head;
    logic           rec_push, rec_deq, q_empty;

    nfcp_front #(.MAX_SECTIONS(MAX_SECTIONS)) u_front (
        .i_clk, .i_rst_n,
        .i_accept(push && !full),
        .i_code_byte, .i_byte_present, .i_code_end,
        .o_rec_push(rec_push), .o_rec(rec_in)
    );

    nfcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(rec_push), .i_data(rec_in), .i_deq(rec_deq),
        .o_full(full), .o_empty(q_empty), .o_head(rec_head)
    );

    nfcp_back u_back (
        .i_clk, .i_rst_n,
        .i_rec_avail(!q_empty), .i_rec(rec_head), .o_rec_deq(rec_deq),
        .pop, .empty,
        .o_kind, .o_out_byte, .o_to_suffix, .o_section_index, .o_decimals,
        .o_section_flags, .o_currency, .o_status, .o_is_general, .o_last_result
    );

endmodule

// ===== hw/rtl/nfcp_front.sv =====
// ----------------------------------------------------------------------------
// nfcp_front
// per byte state tracking, turns one transaction into at most one queued record
// ----------------------------------------------------------------------------
module nfcp_front #(
    parameter int MAX_SECTIONS = nfcp_pkg::MAX_SECTIONS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_code_byte,
    input  logic            i_byte_present,
    input  logic            i_code_end,
    output logic            o_rec_push,
    output nfcp_pkg::t_rec  o_rec
);

    logic              r_in_quote, r_in_decimal, r_seen_digit, r_skip_next;
    logic [7:0]        r_dec;
    logic [4:0]        r_flags;
    logic [2:0]        r_cur;
    logic [2:0]        r_sec;
    logic              r_ovf, r_qpar, r_sec_ne, r_code_ne;
    logic signed [7:0] r_paren;
    logic [7:0]        r_held0, r_held1;
    logic [1:0]        r_hc;
    logic [2:0]        r_gm;
    logic [3:0]        r_glen;

    logic              n_in_quote, n_in_decimal, n_seen_digit, n_skip_next;
    logic [7:0]        n_dec;
    logic [4:0]        n_flags;
    logic [2:0]        n_cur;
    logic [2:0]        n_sec;
    logic              n_ovf, n_qpar, n_sec_ne, n_code_ne;
    logic signed [7:0] n_paren;
    logic [7:0]        n_held0, n_held1;
    logic [1:0]        n_hc;
    logic [2:0]        n_gm;
    logic [3:0]        n_glen;

    nfcp_pkg::t_rec    rec;

    always_comb begin
        logic [7:0] b;
        b = i_code_byte;
        n_in_quote = r_in_quote; n_in_decimal = r_in_decimal;
        n_seen_digit = r_seen_digit; n_skip_next = r_skip_next;
        n_dec = r_dec; n_flags = r_flags; n_cur = r_cur; n_sec = r_sec;
        n_ovf = r_ovf; n_qpar = r_qpar; n_sec_ne = r_sec_ne; n_code_ne = r_code_ne;
        n_paren = r_paren; n_held0 = r_held0; n_held1 = r_held1; n_hc = r_hc;
        n_gm = r_gm; n_glen = r_glen;
        rec = '0;
        rec.suffix  = r_seen_digit;
        rec.lit_idx = r_sec[1:0];

        if (i_byte_present) begin
            n_code_ne = 1'b1;
            if (r_glen < 4'd7) begin
                for (int i = 0; i < 3; i++) begin
                    if (nfcp_pkg::gen_char(2'(i), r_glen[2:0]) != b) begin
                        n_gm[i] = 1'b0;
                    end
                end
            end else begin
                n_gm = 3'd0;
            end
            if (r_glen != 4'd15) begin
                n_glen = r_glen + 4'd1;
            end

            if (b == 8'h3b && !r_qpar) begin
                // section split
                if (r_hc != 2'd0) rec.lits = nfcp_pkg::add_lit(rec.lits, r_held0);
                if (r_hc == 2'd2) rec.lits = nfcp_pkg::add_lit(rec.lits, r_held1);
                rec.sum_a.valid = 1'b1;
                rec.sum_a.idx   = r_sec[1:0];
                rec.sum_a.dec   = r_dec;
                rec.sum_a.flags = {!r_sec_ne, r_flags[3:0]};
                rec.sum_a.cur   = r_cur;
                n_in_quote = 1'b0; n_in_decimal = 1'b0; n_seen_digit = 1'b0;
                n_skip_next = 1'b0; n_dec = 8'd0; n_flags = 5'd0;
                n_cur = nfcp_pkg::CUR_NONE; n_hc = 2'd0; n_sec_ne = 1'b0;
                if ({1'b0, r_sec} + 4'd1 >= 4'(MAX_SECTIONS)) n_ovf = 1'b1;
                n_sec = r_sec + 3'd1;
            end else begin
                if (b == 8'h22) begin
                    n_qpar = !r_qpar;
                end else if (!r_qpar) begin
                    if (b == 8'h28 && r_paren != 8'sd127) n_paren = r_paren + 8'sd1;
                    else if (b == 8'h29 && r_paren != -8'sd128) n_paren = r_paren - 8'sd1;
                end
                n_sec_ne = 1'b1;
                if (r_skip_next) begin
                    n_skip_next = 1'b0;
                end else if (r_hc == 2'd1 && r_held0 == 8'hc2 &&
                             (b == 8'ha3 || b == 8'ha4 || b == 8'ha5)) begin
                    rec.lits = nfcp_pkg::add_lit(rec.lits, 8'hc2);
                    rec.lits = nfcp_pkg::add_lit(rec.lits, b);
                    n_cur = (b == 8'ha3) ? nfcp_pkg::CUR_POUND :
                            (b == 8'ha5) ? nfcp_pkg::CUR_YEN : nfcp_pkg::CUR_GENERIC;
                    n_hc = 2'd0;
                end else if (r_hc == 2'd1 && r_held0 == 8'he2 && b == 8'h82) begin
                    n_held1 = b;
                    n_hc = 2'd2;
                end else if (r_hc == 2'd2 && b == 8'hac) begin
                    rec.lits = nfcp_pkg::add_lit(rec.lits, 8'he2);
                    rec.lits = nfcp_pkg::add_lit(rec.lits, 8'h82);
                    rec.lits = nfcp_pkg::add_lit(rec.lits, 8'hac);
                    n_cur = nfcp_pkg::CUR_EURO;
                    n_hc = 2'd0;
                end else begin
                    if (r_hc != 2'd0) rec.lits = nfcp_pkg::add_lit(rec.lits, r_held0);
                    if (r_hc == 2'd2) rec.lits = nfcp_pkg::add_lit(rec.lits, r_held1);
                    n_hc = 2'd0;
                    if (b == 8'h22) begin
                        n_in_quote = !r_in_quote;
                    end else if (r_in_quote) begin
                        rec.lits = nfcp_pkg::add_lit(rec.lits, b);
                    end else if (b == 8'hc2 || b == 8'he2) begin
                        n_held0 = b;
                        n_hc = 2'd1;
                    end else if (b == 8'h24) begin
                        rec.lits = nfcp_pkg::add_lit(rec.lits, b);
                        n_cur = nfcp_pkg::CUR_DOLLAR;
                    end else if (b == 8'h30 || b == 8'h23) begin
                        n_seen_digit = 1'b1;
                        if (r_in_decimal && r_dec != 8'hff) n_dec = r_dec + 8'd1;
                    end else if (b == 8'h2e) begin
                        n_in_decimal = 1'b1;
                    end else if (b == 8'h2c) begin
                        if (!r_in_decimal && r_seen_digit)
                            n_flags = r_flags | nfcp_pkg::FLAG_THOUSANDS;
                    end else if (b == 8'h40) begin
                        n_flags = r_flags | nfcp_pkg::FLAG_TEXT;
                    end else if (b == 8'h5f || b == 8'h2a) begin
                        n_skip_next = 1'b1;
                    end else begin
                        if (b == 8'h25) n_flags = r_flags | nfcp_pkg::FLAG_PERCENT;
                        if ((b == 8'h28 && !r_seen_digit) || (b == 8'h29 && r_seen_digit))
                            n_flags = r_flags | nfcp_pkg::FLAG_PARENS;
                        rec.lits = nfcp_pkg::add_lit(rec.lits, b);
                    end
                end
            end
        end

        if (i_code_end) begin
            rec.has_verdict = 1'b1;
            if (!n_code_ne) begin
                rec.status = nfcp_pkg::ST_EMPTY;
            end else begin
                if (n_hc != 2'd0) rec.lits = nfcp_pkg::add_lit(rec.lits, n_held0);
                if (n_hc == 2'd2) rec.lits = nfcp_pkg::add_lit(rec.lits, n_held1);
                rec.sum_b.valid = 1'b1;
                rec.sum_b.idx   = n_sec[1:0];
                rec.sum_b.dec   = n_dec;
                rec.sum_b.flags = {!n_sec_ne, n_flags[3:0]};
                rec.sum_b.cur   = n_cur;
                if (n_gm != 3'd0 && n_glen == 4'd7) rec.gen = 1'b1;
                else if (n_ovf) rec.status = nfcp_pkg::ST_SECTIONS;
                else if (n_qpar) rec.status = nfcp_pkg::ST_QUOTES;
                else if (n_paren != 8'sd0) rec.status = nfcp_pkg::ST_PARENS;
            end
            n_in_quote = 1'b0; n_in_decimal = 1'b0; n_seen_digit = 1'b0;
            n_skip_next = 1'b0; n_dec = 8'd0; n_flags = 5'd0;
            n_cur = nfcp_pkg::CUR_NONE; n_hc = 2'd0; n_sec_ne = 1'b0;
            n_sec = 3'd0; n_ovf = 1'b0; n_qpar = 1'b0; n_paren = 8'sd0;
            n_code_ne = 1'b0; n_gm = 3'b111; n_glen = 4'd0;
        end
    end

    assign o_rec = rec;
    assign o_rec_push = i_accept && (rec.lits.n != 2'd0 || rec.sum_a.valid ||
                                     rec.sum_b.valid || rec.has_verdict);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_quote <= 1'b0; r_in_decimal <= 1'b0; r_seen_digit <= 1'b0;
            r_skip_next <= 1'b0; r_dec <= 8'd0; r_flags <= 5'd0;
            r_cur <= nfcp_pkg::CUR_NONE; r_sec <= 3'd0; r_ovf <= 1'b0;
            r_qpar <= 1'b0; r_sec_ne <= 1'b0; r_code_ne <= 1'b0;
            r_paren <= 8'sd0; r_hc <= 2'd0; r_gm <= 3'b111; r_glen <= 4'd0;
        end else if (i_accept) begin
            r_in_quote <= n_in_quote; r_in_decimal <= n_in_decimal;
            r_seen_digit <= n_seen_digit; r_skip_next <= n_skip_next;
            r_dec <= n_dec; r_flags <= n_flags; r_cur <= n_cur; r_sec <= n_sec;
            r_ovf <= n_ovf; r_qpar <= n_qpar; r_sec_ne <= n_sec_ne;
            r_code_ne <= n_code_ne; r_paren <= n_paren; r_hc <= n_hc;
            r_gm <= n_gm; r_glen <= n_glen;
        end
    end

    // held bytes carry no reset, the count guards them
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

endmodule

// ===== hw/rtl/nfcp_queue.sv =====
// ----------------------------------------------------------------------------
// nfcp_queue
// short record queue between front and back
// ----------------------------------------------------------------------------
module nfcp_queue #(
    parameter int DEPTH = nfcp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  nfcp_pkg::t_rec  i_data,
    input  logic            i_deq,
    output logic            o_full,
    output logic            o_empty,
    output nfcp_pkg::t_rec  o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    nfcp_pkg::t_rec  r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_deq && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (do_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            if (do_push && !do_pop) r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

// ===== hw/rtl/nfcp_back.sv =====
// ----------------------------------------------------------------------------
// nfcp_back
// expands queued records into result transactions, one per cycle while the output is empty or popped
// ----------------------------------------------------------------------------
module nfcp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rec_avail,
    input  nfcp_pkg::t_rec  i_rec,
    output logic            o_rec_deq,
    input  logic            pop,
    output logic            empty,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_out_byte,
    output logic            o_to_suffix,
    output logic [1:0]      o_section_index,
    output logic [7:0]      o_decimals,
    output logic [4:0]      o_section_flags,
    output logic [2:0]      o_currency,
    output logic [2:0]      o_status,
    output logic            o_is_general,
    output logic            o_last_result
);

    localparam int NS = nfcp_pkg::NSLOT;

    logic          r_valid;
    logic [NS-1:0] r_done;
    logic [1:0]    r_kind;
    logic [7:0]    r_byte, r_dec;
    logic          r_suf, r_gen, r_last;
    logic [1:0]    r_idx;
    logic [4:0]    r_flags;
    logic [2:0]    r_cur, r_stat;

    logic [NS-1:0] mask, rem, sel;
    logic          load, last;
    nfcp_pkg::t_summary sum;

    always_comb begin
        mask = {i_rec.has_verdict, i_rec.sum_b.valid, i_rec.sum_a.valid,
                i_rec.lits.n == 2'd3, i_rec.lits.n >= 2'd2, i_rec.lits.n != 2'd0};
        rem = mask & ~r_done;
        sel = rem & (~rem + NS'(1));
        last = ((rem & ~sel) == '0);
        sum = sel[nfcp_pkg::SLOT_SUM_A] ? i_rec.sum_a : i_rec.sum_b;
    end

    assign load      = i_rec_avail && (!r_valid || pop);
    assign o_rec_deq = load && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= '0;
        end else begin
            if (load) r_valid <= 1'b1;
            else if (pop) r_valid <= 1'b0;
            if (load) r_done <= last ? '0 : (r_done | sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last  <= last;
            r_byte  <= 8'd0; r_suf <= 1'b0; r_idx <= 2'd0; r_dec <= 8'd0;
            r_flags <= 5'd0; r_cur <= nfcp_pkg::CUR_NONE;
            r_stat  <= nfcp_pkg::ST_VALID; r_gen <= 1'b0;
            if (sel[nfcp_pkg::SLOT_VERD]) begin
                r_kind <= nfcp_pkg::KIND_VERDICT;
                r_stat <= i_rec.status;
                r_gen  <= i_rec.gen;
            end else if (sel[nfcp_pkg::SLOT_SUM_A] || sel[nfcp_pkg::SLOT_SUM_B]) begin
                r_kind  <= nfcp_pkg::KIND_SUMMARY;
                r_idx   <= sum.idx;
                r_dec   <= sum.dec;
                r_flags <= sum.flags;
                r_cur   <= sum.cur;
            end else begin
                r_kind <= nfcp_pkg::KIND_LITERAL;
                r_byte <= sel[2] ? i_rec.lits.b[2] : sel[1] ? i_rec.lits.b[1] :
                          i_rec.lits.b[0];
                r_suf  <= i_rec.suffix;
                r_idx  <= i_rec.lit_idx;
            end
        end
    end

    assign empty           = !r_valid;
    assign o_kind          = r_kind;
    assign o_out_byte      = r_byte;
    assign o_to_suffix     = r_suf;
    assign o_section_index = r_idx;
    assign o_decimals      = r_dec;
    assign o_section_flags = r_flags;
    assign o_currency      = r_cur;
    assign o_status        = r_stat;
    assign o_is_general    = r_gen;
    assign o_last_result   = r_last;

`ifndef SYNTHESIS
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == nfcp_pkg::KIND_VERDICT) |-> r_last)
        else $error("verdict not flagged last");
    a_one_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> $onehot(sel))
        else $error("record slot select not one-hot");
    a_deq_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rec_deq |=> (r_done == '0))
        else $error("slot mask not cleared after record");
`endif

endmodule
